// File: rtl/cdte_pkg.sv
// Shared types, constants and the month table for the civil date to epoch pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cdte_pkg;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FIELD = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Control flags that ride alongside the datapath
   typedef struct packed {
      logic date_only;
      logic bad_field;
      logic before_epoch;   // January or February of year 0: day count below zero
   } cdte_ctl_type;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned FIELD_W = 7;
   localparam int unsigned DOY_W   = 9;    // day of March-based year, 0..367
   localparam int unsigned TADJ_W  = 22;   // signed time-of-day plus offsets
   localparam int unsigned Y365_W  = 23;
   localparam int unsigned DAYS_W  = 25;   // signed day count
   localparam int unsigned PROD_W  = 40;   // day count times seconds per day
   localparam int unsigned LOCAL_W = 42;   // signed local seconds

   localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
   localparam logic [19:0] EPOCH_DAY_SHIFT = 20'd719468;
   // floor(y / 100) == (y * 5243) >> 19 for every y below 2^14
   localparam logic [12:0] RECIP_100       = 13'd5243;
   localparam int unsigned RECIP_SHIFT     = 19;

   // Days before the first of the month, counted from the first of March
   function automatic logic [DOY_W-1:0] month_start(input logic [FIELD_W-1:0] mon);
      logic [DOY_W-1:0] res;
      unique case (mon)
         7'd3:    res = 9'd0;
         7'd4:    res = 9'd31;
         7'd5:    res = 9'd61;
         7'd6:    res = 9'd92;
         7'd7:    res = 9'd122;
         7'd8:    res = 9'd153;
         7'd9:    res = 9'd184;
         7'd10:   res = 9'd214;
         7'd11:   res = 9'd245;
         7'd12:   res = 9'd275;
         7'd1:    res = 9'd306;
         7'd2:    res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cdte_front.sv
// First stage: field checks, March-based year, day of year and time adjustment.
// Depends on cdte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdte_front
   import cdte_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic                      date_only,
   input  wire logic [YEAR_W-1:0]         year,
   input  wire logic [FIELD_W-1:0]        month,
   input  wire logic [FIELD_W-1:0]        day,
   input  wire logic [FIELD_W-1:0]        hour,
   input  wire logic [FIELD_W-1:0]        minute,
   input  wire logic [FIELD_W-1:0]        second,
   input  wire logic                      offset_present,
   input  wire logic                      offset_negative,
   input  wire logic [FIELD_W-1:0]        offset_hours,
   input  wire logic [FIELD_W-1:0]        offset_mins,
   input  wire logic signed [11:0]        zone_minutes,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output cdte_ctl_type                   out_ctl,
   output logic [YEAR_W-1:0]              out_year,
   output logic [DOY_W-1:0]               out_doy,
   output logic signed [TADJ_W-1:0]       out_tadj
);

   logic                      valid_ff;
   logic                      en;
   cdte_ctl_type              ctl_ff, ctl_in;
   logic [YEAR_W-1:0]         year_ff, year_in;
   logic [DOY_W-1:0]          doy_ff, doy_in;
   logic signed [TADJ_W-1:0]  tadj_ff, tadj_in;

   logic                      early;
   logic [18:0]               tod;
   logic [18:0]               sfx;
   logic signed [TADJ_W-1:0]  zone_secs;
   logic signed [TADJ_W-1:0]  sfx_term;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      early = (month <= 7'd2);
      ctl_in.date_only    = date_only;
      ctl_in.bad_field    = (month < 7'd1) || (month > 7'd12) || (day < 7'd1) ||
                            (day > 7'd31) ||
                            (!date_only && ((hour > 7'd23) || (minute > 7'd59) ||
                                            (second > 7'd60)));
      ctl_in.before_epoch = early && (year == '0);

      year_in = (early && (year != '0)) ? year - 14'd1 : year;
      doy_in  = month_start(month) + {2'b00, day} - 9'd1;

      tod = 19'(hour) * 19'd3600 + 19'(minute) * 19'd60 + 19'(second);
      sfx = 19'(offset_hours) * 19'd3600 + 19'(offset_mins) * 19'd60;

      // suffix is subtracted: a minus sign adds its magnitude back
      if (!offset_present) begin
         sfx_term = '0;
      end else if (offset_negative) begin
         sfx_term = $signed({3'b000, sfx});
      end else begin
         sfx_term = -$signed({3'b000, sfx});
      end

      zone_secs = TADJ_W'(zone_minutes) * 22'sd60;
      tadj_in   = $signed({3'b000, tod}) + sfx_term + zone_secs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff  <= ctl_in;
         year_ff <= year_in;
         doy_ff  <= doy_in;
         tadj_ff <= tadj_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_year  = year_ff;
   assign out_doy   = doy_ff;
   assign out_tadj  = tadj_ff;

endmodule

`default_nettype wire

// File: rtl/cdte_days.sv
// Second and third stages: year products by constant, then the day count from epoch.
// Depends on cdte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdte_days
   import cdte_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire cdte_ctl_type              in_ctl,
   input  wire logic [YEAR_W-1:0]         in_year,
   input  wire logic [DOY_W-1:0]          in_doy,
   input  wire logic signed [TADJ_W-1:0]  in_tadj,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output cdte_ctl_type                   out_ctl,
   output logic [DAYS_W-1:0]              out_days,
   output logic signed [TADJ_W-1:0]       out_tadj
);

   // stage A: 365*y, y/4, y/100
   logic                      va_ff;
   logic                      en_a;
   cdte_ctl_type              ctl_a_ff;
   logic signed [TADJ_W-1:0]  tadj_a_ff;
   logic [DOY_W-1:0]          doy_a_ff;
   logic [Y365_W-1:0]         y365_ff, y365_in;
   logic [11:0]               y4_ff, y4_in;
   logic [7:0]                q100_ff, q100_in;
   logic [26:0]               prod100;

   // stage B: day count
   logic                      vb_ff;
   logic                      en_b;
   cdte_ctl_type              ctl_b_ff;
   logic signed [TADJ_W-1:0]  tadj_b_ff;
   logic [DAYS_W-1:0]         days_ff, days_in;

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      prod100 = 27'(in_year) * 27'(RECIP_100);
      q100_in = prod100[RECIP_SHIFT +: 8];
      y4_in   = in_year[YEAR_W-1:2];
      y365_in = Y365_W'(in_year) * 23'd365;
   end

   // y/400 is taken as (y/100)/4; wraps to a two's complement count
   assign days_in = DAYS_W'(y365_ff) + DAYS_W'(y4_ff) - DAYS_W'(q100_ff) +
                    DAYS_W'(q100_ff[7:2]) + DAYS_W'(doy_a_ff) - DAYS_W'(EPOCH_DAY_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         ctl_a_ff  <= in_ctl;
         tadj_a_ff <= in_tadj;
         doy_a_ff  <= in_doy;
         y365_ff   <= y365_in;
         y4_ff     <= y4_in;
         q100_ff   <= q100_in;
      end
      if (en_b) begin
         ctl_b_ff  <= ctl_a_ff;
         tadj_b_ff <= tadj_a_ff;
         days_ff   <= days_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_ctl   = ctl_b_ff;
   assign out_days  = days_ff;
   assign out_tadj  = tadj_b_ff;

endmodule

`default_nettype wire

// File: rtl/cdte_scale.sv
// Fourth and fifth stages: days to seconds, time adjustment, range check, result word.
// Depends on cdte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdte_scale
   import cdte_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire cdte_ctl_type              in_ctl,
   input  wire logic [DAYS_W-1:0]         in_days,
   input  wire logic signed [TADJ_W-1:0]  in_tadj,
   output logic                           out_valid,
   input  wire logic                      out_stall,
   output logic [31:0]                    out_epoch,
   output status_type                     out_status
);

   // stage A: multiply
   logic                      va_ff;
   logic                      en_a;
   cdte_ctl_type              ctl_a_ff;
   logic signed [TADJ_W-1:0]  tadj_a_ff;
   logic                      neg_ff, neg_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;

   // stage B: output register
   logic                      vb_ff;
   logic                      en_b;
   logic [31:0]               epoch_ff, epoch_in;
   status_type                status_ff, status_in;
   logic signed [LOCAL_W-1:0] local_secs;

   assign en_b     = !vb_ff || !out_stall;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   assign neg_in  = in_ctl.before_epoch || in_days[DAYS_W-1];
   assign prod_in = PROD_W'(in_days[Y365_W-1:0]) * PROD_W'(SECS_PER_DAY);

   always_comb begin
      local_secs = $signed({2'b00, prod_ff}) + LOCAL_W'(tadj_a_ff);
      epoch_in   = '0;
      priority if (ctl_a_ff.bad_field) begin
         status_in = STATUS_FIELD;
      end else if (neg_ff) begin
         status_in = STATUS_RANGE;
      end else if (ctl_a_ff.date_only) begin
         status_in = STATUS_OK;
         epoch_in  = prod_ff[31:0];
      end else if (local_secs[LOCAL_W-1:32] != '0) begin
         status_in = STATUS_RANGE;
      end else begin
         status_in = STATUS_OK;
         epoch_in  = local_secs[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         ctl_a_ff  <= in_ctl;
         tadj_a_ff <= in_tadj;
         neg_ff    <= neg_in;
         prod_ff   <= prod_in;
      end
      if (en_b) begin
         epoch_ff  <= epoch_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = vb_ff;
   assign out_epoch  = epoch_ff;
   assign out_status = status_ff;

endmodule

`default_nettype wire

// File: rtl/civil_datetime_to_epoch.sv
// Top level of the civil date and time to epoch seconds converter.
// Depends on cdte_pkg, cdte_front, cdte_days and cdte_scale.
//
// Usage
//   Request channel (req_*): one word carries parsed date and time fields.
//   A word is taken at a rising clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): one word per request, in order, carrying
//   rsp_epoch_seconds and rsp_status (ok, field out of range, out of range).
//   The receiver holds rsp_stall high to keep the current word in place.
//   csr_wr_en/csr_wr_data write the signed zone offset in minutes; write it
//   only while no request is in flight.
// Timing
//   Five register stages: checks, year products, day count, days times 86400,
//   range check into the output register. One word per cycle is sustained
//   while rsp_stall is low; the pacing unit is the 23 x 17 bit day-to-seconds
//   multiplier stage.
// Reset and stall
//   Synchronous reset empties the pipeline and clears the zone offset to zero.
//   A stall only holds stages that are full: empty stages keep filling, and
//   req_stall rises only once every stage holds a word behind a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module civil_datetime_to_epoch
   import cdte_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration
   input  wire logic                 csr_wr_en,
   input  wire logic [11:0]          csr_wr_data,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_date_only,
   input  wire logic [YEAR_W-1:0]    req_year,
   input  wire logic [FIELD_W-1:0]   req_month,
   input  wire logic [FIELD_W-1:0]   req_day,
   input  wire logic [FIELD_W-1:0]   req_hour,
   input  wire logic [FIELD_W-1:0]   req_minute,
   input  wire logic [FIELD_W-1:0]   req_second,
   input  wire logic                 req_offset_present,
   input  wire logic                 req_offset_negative,
   input  wire logic [FIELD_W-1:0]   req_offset_hours,
   input  wire logic [FIELD_W-1:0]   req_offset_mins,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [31:0]               rsp_epoch_seconds,
   output logic [1:0]                rsp_status
);

   logic signed [11:0]        zone_ff;

   logic                      front_ready;
   logic                      front_valid;
   cdte_ctl_type              front_ctl;
   logic [YEAR_W-1:0]         front_year;
   logic [DOY_W-1:0]          front_doy;
   logic signed [TADJ_W-1:0]  front_tadj;

   logic                      days_ready;
   logic                      days_valid;
   cdte_ctl_type              days_ctl;
   logic [DAYS_W-1:0]         days_count;
   logic signed [TADJ_W-1:0]  days_tadj;

   logic                      scale_ready;
   status_type                status_word;

   // zone offset register, used as given for any 12-bit value
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
      end else if (csr_wr_en) begin
         zone_ff <= $signed(csr_wr_data);
      end
   end

   assign req_stall = !front_ready;

   cdte_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (front_ready),
      .date_only       (req_date_only),
      .year            (req_year),
      .month           (req_month),
      .day             (req_day),
      .hour            (req_hour),
      .minute          (req_minute),
      .second          (req_second),
      .offset_present  (req_offset_present),
      .offset_negative (req_offset_negative),
      .offset_hours    (req_offset_hours),
      .offset_mins     (req_offset_mins),
      .zone_minutes    (zone_ff),
      .out_valid       (front_valid),
      .out_ready       (days_ready),
      .out_ctl         (front_ctl),
      .out_year        (front_year),
      .out_doy         (front_doy),
      .out_tadj        (front_tadj)
   );

   cdte_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (days_ready),
      .in_ctl    (front_ctl),
      .in_year   (front_year),
      .in_doy    (front_doy),
      .in_tadj   (front_tadj),
      .out_valid (days_valid),
      .out_ready (scale_ready),
      .out_ctl   (days_ctl),
      .out_days  (days_count),
      .out_tadj  (days_tadj)
   );

   cdte_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (days_valid),
      .in_ready   (scale_ready),
      .in_ctl     (days_ctl),
      .in_days    (days_count),
      .in_tadj    (days_tadj),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_epoch  (rsp_epoch_seconds),
      .out_status (status_word)
   );

   assign rsp_status = status_word;

`ifndef NO_ASSERTIONS
   // any error word carries a zero epoch
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_epoch_seconds == '0))
      else $error("error word with non-zero epoch");

   // back-pressure only originates at a stalled, full output
   a_stall_src : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without output stall");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // zone register moves only on a write
   a_zone_hold : assert property (@(posedge clock) disable iff (reset)
      !$past(csr_wr_en) && !$past(reset) |-> $stable(zone_ff))
      else $error("zone offset changed without a write");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for civil_datetime_to_epoch: directed calendar corners, zone offset
// sweeps, a long random mix and an output hold-off, all scored against a local predictor.
// Needs cdte_pkg and the block's RTL only.

module testbench;
   import cdte_pkg::*;

   localparam int     HOLD_CYCLES = 60;   // long receiver hold-off, enough to fill the pipe
   localparam int     LATENCY     = 4;    // edges from request accept to rsp_valid
   localparam longint EPOCH_MAX   = 64'd4294967295;

   // One request word as the block sees it
   typedef struct {
      logic               date_only;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic               offset_present;
      logic               offset_negative;
      logic [FIELD_W-1:0] offset_hours;
      logic [FIELD_W-1:0] offset_mins;
   } timestamp_type;

   typedef struct {
      logic [31:0] epoch;
      status_type  status;
   } epoch_result_type;

   // Kinds of random request: clean date-time, clean date-only, near the ends of
   // the 32-bit range, and raw noise over the full field widths
   typedef enum int {
      SHAPE_CLOCK,
      SHAPE_DATE,
      SHAPE_EDGE,
      SHAPE_NOISE
   } stamp_shape_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [11:0]         csr_wr_data;
   logic                req_valid;
   logic                req_stall;
   logic                req_date_only;
   logic [YEAR_W-1:0]   req_year;
   logic [FIELD_W-1:0]  req_month;
   logic [FIELD_W-1:0]  req_day;
   logic [FIELD_W-1:0]  req_hour;
   logic [FIELD_W-1:0]  req_minute;
   logic [FIELD_W-1:0]  req_second;
   logic                req_offset_present;
   logic                req_offset_negative;
   logic [FIELD_W-1:0]  req_offset_hours;
   logic [FIELD_W-1:0]  req_offset_mins;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [31:0]         rsp_epoch_seconds;
   logic [1:0]          rsp_status;

   // Predictor state: the zone register as last written
   longint              zone_offset_min = 0;
   epoch_result_type    due_results[$];

   // Pacing knobs shared by the sender, the receiver and the test tasks
   bit                  tx_idle = 1'b1;
   bit                  rx_idle = 1'b1;
   bit                  hold_request = 1'b0;

   int                  fail_count = 0;
   int                  words_sent = 0;
   int                  zone_writes = 0;
   int                  input_stall_cycles = 0;
   int                  status_tally[3] = '{0, 0, 0};

   civil_datetime_to_epoch uut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_date_only       (req_date_only),
      .req_year            (req_year),
      .req_month           (req_month),
      .req_day             (req_day),
      .req_hour            (req_hour),
      .req_minute          (req_minute),
      .req_second          (req_second),
      .req_offset_present  (req_offset_present),
      .req_offset_negative (req_offset_negative),
      .req_offset_hours    (req_offset_hours),
      .req_offset_mins     (req_offset_mins),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_epoch_seconds   (rsp_epoch_seconds),
      .rsp_status          (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: seconds since 1970-01-01 from the calendar fields, using the
   // Gregorian days-from-civil rule on a March-based year in 400-year eras.
   // ---------------------------------------------------------------------------
   function automatic epoch_result_type predict_epoch(timestamp_type w);
      epoch_result_type res;
      longint yr, mon, dom, hr, mn, sc, era, yoe, doy, days, shift, secs;
      yr  = w.year;
      mon = w.month;
      dom = w.day;
      hr  = w.hour;
      mn  = w.minute;
      sc  = w.second;
      res.epoch  = '0;
      res.status = STATUS_OK;
      // Day is only checked against 1..31; time fields only matter in date-time form
      if (mon < 1 || mon > 12 || dom < 1 || dom > 31 ||
          (!w.date_only && (hr > 23 || mn > 59 || sc > 60))) begin
         res.status = STATUS_FIELD;
      end else begin
         // January and February belong to the previous March-based year,
         // which puts the leap day last and lets an overflowing day roll on
         if (mon <= 2) yr = yr - 1;
         era  = (yr >= 0 ? yr : yr - 399) / 400;
         yoe  = yr - era * 400;
         doy  = (153 * (mon > 2 ? mon - 3 : mon + 9) + 2) / 5 + dom - 1;
         days = era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
         if (days < 0) begin
            res.status = STATUS_RANGE;
         end else if (w.date_only) begin
            // no offsets, product simply wraps at 32 bits
            res.epoch = 32'(days * 86400);
         end else begin
            shift = 0;
            if (w.offset_present) begin
               shift = longint'(w.offset_hours) * 3600 + longint'(w.offset_mins) * 60;
               if (w.offset_negative) shift = -shift;
            end
            // suffix offset back to UTC, then the zone register on to local time
            secs = days * 86400 + hr * 3600 + mn * 60 + sc - shift + zone_offset_min * 60;
            if (secs < 0 || secs > EPOCH_MAX) begin
               res.status = STATUS_RANGE;
            end else begin
               res.epoch = 32'(secs);
            end
         end
      end
      return res;
   endfunction

   function automatic timestamp_type stamp(bit donly, int y, int mo, int d, int h, int mi,
                                           int s, bit op, bit neg, int oh, int om);
      timestamp_type w;
      w.date_only       = donly;
      w.year            = YEAR_W'(y);
      w.month           = FIELD_W'(mo);
      w.day             = FIELD_W'(d);
      w.hour            = FIELD_W'(h);
      w.minute          = FIELD_W'(mi);
      w.second          = FIELD_W'(s);
      w.offset_present  = op;
      w.offset_negative = neg;
      w.offset_hours    = FIELD_W'(oh);
      w.offset_mins     = FIELD_W'(om);
      return w;
   endfunction

   function automatic timestamp_type random_stamp(stamp_shape_type shape);
      timestamp_type w;
      // default: a clean date-time around the 32-bit epoch window
      w = stamp(1'b0, $urandom_range(1969, 2106), $urandom_range(1, 12),
                $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                $urandom_range(0, 60), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 14),
                $urandom_range(0, 59));
      case (shape)
         SHAPE_DATE: begin
            // time and offset fields are don't-care here, so fill them with junk
            w.date_only       = 1'b1;
            w.year            = YEAR_W'($urandom_range(0, 9999));
            w.hour            = FIELD_W'($urandom);
            w.minute          = FIELD_W'($urandom);
            w.second          = FIELD_W'($urandom);
            w.offset_hours    = FIELD_W'($urandom);
            w.offset_mins     = FIELD_W'($urandom);
         end
         SHAPE_EDGE: begin
            if ($urandom_range(0, 1) == 1) begin
               w.year  = YEAR_W'(1970);
               w.month = FIELD_W'(1);
               w.day   = FIELD_W'(1);
               w.hour  = FIELD_W'($urandom_range(0, 1));
            end else begin
               // 2106-02-07 06:28:15 is the last representable second
               w.year   = YEAR_W'(2106);
               w.month  = FIELD_W'(2);
               w.day    = FIELD_W'(7);
               w.hour   = FIELD_W'($urandom_range(5, 6));
               w.minute = FIELD_W'($urandom_range(25, 31));
            end
            w.offset_hours = FIELD_W'($urandom_range(0, 2));
         end
         SHAPE_NOISE: begin
            w.date_only       = 1'($urandom);
            w.year            = YEAR_W'($urandom);
            w.month           = FIELD_W'($urandom);
            w.day             = FIELD_W'($urandom);
            w.hour            = FIELD_W'($urandom);
            w.minute          = FIELD_W'($urandom);
            w.second          = FIELD_W'($urandom);
            w.offset_present  = 1'($urandom);
            w.offset_negative = 1'($urandom);
            w.offset_hours    = FIELD_W'($urandom);
            w.offset_mins     = FIELD_W'($urandom);
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic stamp_shape_type pick_shape();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return SHAPE_CLOCK;
      if (roll < 75) return SHAPE_DATE;
      if (roll < 85) return SHAPE_EDGE;
      return SHAPE_NOISE;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: optional idle gap, then hold the word until it is taken.
   // valid stays high across back-to-back words, so it is only lowered when a
   // gap is actually drawn.
   // ---------------------------------------------------------------------------
   task automatic send_word(timestamp_type w);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_date_only       <= w.date_only;
      req_year            <= w.year;
      req_month           <= w.month;
      req_day             <= w.day;
      req_hour            <= w.hour;
      req_minute          <= w.minute;
      req_second          <= w.second;
      req_offset_present  <= w.offset_present;
      req_offset_negative <= w.offset_negative;
      req_offset_hours    <= w.offset_hours;
      req_offset_mins     <= w.offset_mins;
      @(posedge clock);
      while (req_stall) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      due_results = {due_results, predict_epoch(w)};
      words_sent++;
   endtask

   // Drop valid and wait for every outstanding word to come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
   endtask

   // Zone register is only touched with the pipe empty
   task automatic write_zone(logic [11:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en       <= 1'b0;
      zone_offset_min = longint'($signed(value));
      zone_writes++;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes and calendar corner cases, zone at its reset value
   task automatic test_field_limits();
      send_word(stamp(0, 1970, 1, 1, 0, 0, 0, 0, 0, 0, 0));           // epoch itself
      send_word(stamp(1, 1970, 1, 1, 127, 127, 127, 1, 1, 127, 127)); // date-only ignores junk
      send_word(stamp(0, 2106, 2, 7, 6, 28, 15, 0, 0, 0, 0));         // last 32-bit second
      send_word(stamp(0, 2106, 2, 7, 6, 28, 16, 0, 0, 0, 0));         // one past it
      send_word(stamp(0, 2106, 2, 7, 6, 28, 15, 1, 1, 0, 1));         // pushed over by -00:01
      send_word(stamp(0, 1969, 12, 31, 23, 59, 59, 0, 0, 0, 0));      // day before epoch
      send_word(stamp(0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));              // year 0, previous era
      send_word(stamp(1, 9999, 12, 31, 0, 0, 0, 0, 0, 0, 0));         // date-only wrap
      send_word(stamp(1, 16383, 3, 1, 0, 0, 0, 0, 0, 0, 0));          // all-ones year
      send_word(stamp(0, 2000, 0, 1, 0, 0, 0, 0, 0, 0, 0));           // month 0
      send_word(stamp(0, 2000, 13, 1, 0, 0, 0, 0, 0, 0, 0));          // month 13
      send_word(stamp(1, 2000, 127, 127, 0, 0, 0, 0, 0, 0, 0));       // all-ones month/day
      send_word(stamp(0, 2000, 6, 0, 0, 0, 0, 0, 0, 0, 0));           // day 0
      send_word(stamp(1, 2000, 6, 32, 0, 0, 0, 0, 0, 0, 0));          // day 32
      send_word(stamp(0, 2000, 6, 15, 24, 0, 0, 0, 0, 0, 0));         // hour 24
      send_word(stamp(0, 2000, 6, 15, 0, 60, 0, 0, 0, 0, 0));         // minute 60
      send_word(stamp(0, 2000, 6, 15, 0, 0, 61, 0, 0, 0, 0));         // second 61
      send_word(stamp(0, 2016, 12, 31, 23, 59, 60, 0, 0, 0, 0));      // leap second accepted
      send_word(stamp(0, 2000, 2, 29, 12, 0, 0, 0, 0, 0, 0));         // real leap day
      send_word(stamp(0, 2100, 2, 29, 12, 0, 0, 0, 0, 0, 0));         // rolls into March
      send_word(stamp(1, 2023, 2, 31, 0, 0, 0, 0, 0, 0, 0));          // rolls into March
      send_word(stamp(0, 1970, 1, 1, 0, 0, 0, 1, 0, 14, 0));          // +14:00 goes negative
      send_word(stamp(0, 1970, 1, 1, 0, 0, 0, 1, 1, 12, 0));          // -12:00 stays positive
      send_word(stamp(0, 2001, 9, 9, 1, 46, 40, 0, 1, 99, 99));       // suffix absent: ignored
      send_word(stamp(0, 2001, 9, 9, 1, 46, 40, 1, 0, 99, 99));       // suffix not range checked
   endtask

   // Sweep the zone register over its legal limits and the full 12-bit extremes
   task automatic test_zone_settings();
      logic [11:0] zone_steps[6];
      zone_steps = '{12'(1440), 12'(-1440), 12'h7FF, 12'h800, 12'($urandom), 12'(0)};
      foreach (zone_steps[i]) begin
         write_zone(zone_steps[i]);
         repeat (15) send_word(random_stamp(($urandom_range(0, 1) == 1) ? SHAPE_EDGE
                                                                        : pick_shape()));
      end
   endtask

   // Bulk random traffic in blocks, with the idle pattern changing per block
   task automatic test_random_mix();
      for (int blk = 0; blk < 8; blk++) begin
         tx_idle = !(blk == 1 || blk == 3 || blk == 6);
         rx_idle = !(blk == 3 || blk == 5 || blk == 6);
         if (blk == 4) write_zone(12'($urandom_range(0, 2880) - 1440));
         repeat (50) send_word(random_stamp(pick_shape()));
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   // Receiver holds off while the sender keeps offering words back to back,
   // so the pipe fills and the block has to stall its input
   task automatic test_output_hold();
      write_zone(12'(0));
      tx_idle      = 1'b0;
      rx_idle      = 1'b0;
      hold_request = 1'b1;
      repeat (40) send_word(random_stamp(pick_shape()));
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: draws a stall per word, or a long hold when asked
   // ---------------------------------------------------------------------------
   initial begin : result_drain
      int pause;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            pause        = HOLD_CYCLES;
         end else begin
            pause = rx_idle ? $urandom_range(0, 7) : 0;
         end
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Checker: every word taken off the result channel against the oldest prediction
   always @(posedge clock) begin : result_check
      epoch_result_type due_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("unexpected result word: epoch_seconds %0d status %0d",
                   rsp_epoch_seconds, rsp_status);
            fail_count++;
         end else begin
            due_word = due_results.pop_front();
            status_tally[due_word.status]++;
            if (rsp_epoch_seconds !== due_word.epoch) begin
               $error("epoch_seconds: expected %0d, got %0d", due_word.epoch,
                      rsp_epoch_seconds);
               fail_count++;
            end
            if (rsp_status !== due_word.status) begin
               $error("status: expected %0d, got %0d", due_word.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : run
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_valid           = 1'b0;
      req_date_only       = 1'b0;
      req_year            = '0;
      req_month           = '0;
      req_day             = '0;
      req_hour            = '0;
      req_minute          = '0;
      req_second          = '0;
      req_offset_present  = 1'b0;
      req_offset_negative = 1'b0;
      req_offset_hours    = '0;
      req_offset_mins     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_field_limits();
      test_zone_settings();
      test_random_mix();
      test_output_hold();

      // let any stray word show up before scoring
      drain_results();
      repeat (LATENCY + 10) @(negedge clock);

      $display("summary: %0d words checked (%0d ok, %0d bad field, %0d out of range)",
               words_sent, status_tally[STATUS_OK], status_tally[STATUS_FIELD],
               status_tally[STATUS_RANGE]);
      $display("summary: %0d zone writes, request side held off for %0d cycles",
               zone_writes, input_stall_cycles);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// File: civil_datetime_to_epoch.f
rtl/cdte_pkg.sv
rtl/cdte_front.sv
rtl/cdte_days.sv
rtl/cdte_scale.sv
rtl/civil_datetime_to_epoch.sv
bench/testbench.sv
